// ===== design/wsg_pkg.sv =====
`timescale 1ns / 1ps
// Types, register codes and shared arithmetic helpers for the wheel slip grouping unit.
// Depends on nothing; every other file of the block but wsg_stream_if imports it.
package wsg_pkg;

    localparam int VAL_W  = 32;
    localparam int ANG_W  = 31;
    localparam int RATE_W = 20;
    localparam int POLE_W = 17;

    localparam logic [RATE_W-1:0] RATE_CAP = 20'd1000000;
    localparam logic [POLE_W-1:0] POLE_ONE = 17'd65536;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [ANG_W-1:0]        ang_t;
    typedef logic [1:0]              wheel_t;

    localparam wheel_t WHEEL_RR = 2'd3;

    localparam logic signed [63:0] VMAX64 = 64'sd2147483647;
    localparam logic signed [63:0] VMIN64 = -64'sd2147483648;
    localparam val_t VAL_MAX = 32'sh7FFFFFFF;
    localparam val_t VAL_MIN = 32'sh80000000;

    typedef enum logic [2:0] {
        REG_ABS_VIRTUAL = 3'd0,
        REG_ABS_WEIGHT  = 3'd1,
        REG_TC_VIRTUAL  = 3'd2,
        REG_TC_WEIGHT   = 3'd3,
        REG_ABS_GROUP   = 3'd4,
        REG_TC_GROUP    = 3'd5,
        REG_SAMPLE_RATE = 3'd6,
        REG_ANGLE_POLE  = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        GRP_INDIVIDUAL = 2'd0,
        GRP_AXLE       = 2'd1,
        GRP_ALL        = 2'd2,
        GRP_REAR       = 2'd3
    } grp_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_WPROD,
        ST_WPREP,
        ST_WWAIT,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        wheel_t wheel;
        val_t   wheel_slip;
        val_t   virtual_wheel_slip;
        val_t   wheel_load;
        val_t   wheel_slip_angle;
    } wheel_item_t;

    typedef struct packed {
        wheel_t out_wheel;
        val_t   abs_slip;
        ang_t   abs_angle;
        val_t   abs_rate;
        val_t   tc_slip;
        ang_t   tc_angle;
        val_t   tc_rate;
        logic   final_wheel;
    } result_t;

    typedef struct packed {
        logic [2:0]        index;
        logic [RATE_W-1:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic      virt;
        logic      weight;
        grp_mode_t mode;
    } ctrl_src_t;

    typedef struct packed {
        val_t slip;
        val_t vslip;
        val_t load;
        val_t angle;
    } frame_entry_t;

    typedef struct packed {
        val_t prev;
        val_t filt;
    } wheel_state_t;

    function automatic val_t sat_val(input logic signed [63:0] v);
        val_t r;
        if (v > VMAX64) r = VAL_MAX;
        else if (v < VMIN64) r = VAL_MIN;
        else r = v[VAL_W-1:0];
        return r;
    endfunction

    function automatic ang_t abs_ang(input val_t v);
        val_t n;
        ang_t r;
        n = -v;
        if (v == VAL_MIN) r = '1;
        else if (v < 0) r = n[ANG_W-1:0];
        else r = v[ANG_W-1:0];
        return r;
    endfunction

endpackage

// ===== design/wsg_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one item of a chosen payload type.
// Used for the wheel, result and configuration channels of the grouping unit.
interface wsg_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/wsg_frame_mem.sv =====
`timescale 1ns / 1ps
// Frame store: the last item of each wheel, one write and one registered read port.
// Depends on wsg_pkg.
module wsg_frame_mem (
    input  logic                  clk,
    input  logic                  wr_en,
    input  wsg_pkg::wheel_t       wr_addr,
    input  wsg_pkg::frame_entry_t wr_data,
    input  logic                  rd_en,
    input  wsg_pkg::wheel_t       rd_addr,
    output wsg_pkg::frame_entry_t rd_data
);
    import wsg_pkg::*;

    frame_entry_t mem [4];
    frame_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== design/wsg_state_mem.sv =====
`timescale 1ns / 1ps
// Per-wheel previous slip and angle filter state, cleared by valid bits at reset.
// Depends on wsg_pkg.
module wsg_state_mem (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  wsg_pkg::wheel_t       wr_addr,
    input  wsg_pkg::wheel_state_t wr_data,
    input  logic                  rd_en,
    input  wsg_pkg::wheel_t       rd_addr,
    output wsg_pkg::wheel_state_t rd_data
);
    import wsg_pkg::*;

    wheel_state_t mem [4];
    wheel_state_t rd_raw_reg;
    logic [3:0]   valid_reg;
    logic         rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;
endmodule

// ===== design/wsg_div.sv =====
`timescale 1ns / 1ps
// Restoring divider for the axle weighting, two quotient bits per cycle.
// Depends on wsg_pkg.
module wsg_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   dividend,
    input  logic [31:0]   divisor,
    output logic          done,
    output wsg_pkg::ang_t quotient,
    output logic          overflow
);
    import wsg_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] sh_reg, sh_next;
    logic [31:0] div_reg, div_next;
    logic        ovf_reg, ovf_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] step1, step2;

    function automatic logic [63:0] div_step(input logic [31:0] rem, input logic [31:0] sh,
                                             input logic [31:0] d);
        logic [32:0] t;
        logic [32:0] diff;
        t    = {rem, sh[31]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) return {diff[31:0], sh[30:0], 1'b1};
        return {t[31:0], sh[30:0], 1'b0};
    endfunction

    // The quotient is known to fit 31 bits unless the top part already reaches the divisor.
    always_comb
    begin
        step1     = div_step(rem_reg, sh_reg, div_reg);
        step2     = div_step(step1[63:32], step1[31:0], div_reg);
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        div_next  = div_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[63:32];
            sh_next   = dividend[31:0];
            div_next  = divisor;
            ovf_next  = dividend[63:31] >= {1'b0, divisor};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = step2[63:32];
            sh_next  = step2[31:0];
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'hF)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        div_reg <= div_next;
        ovf_reg <= ovf_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg[ANG_W-1:0];
    assign overflow = ovf_reg;
endmodule

// ===== design/wsg_group.sv =====
`timescale 1ns / 1ps
// Source selection and wheel grouping for one controller, giving one wheel's values.
// Depends on wsg_pkg.
module wsg_group (
    input  logic               is_min,
    input  wsg_pkg::ctrl_src_t ctrl,
    input  wsg_pkg::wheel_t    idx,
    input  wsg_pkg::val_t      raw [4],
    input  wsg_pkg::val_t      vs [4],
    input  wsg_pkg::val_t      wt [4],
    input  wsg_pkg::val_t      rr [4],
    input  wsg_pkg::ang_t      ang [4],
    output wsg_pkg::val_t      slip,
    output wsg_pkg::ang_t      angle,
    output wsg_pkg::val_t      rate
);
    import wsg_pkg::*;

    val_t   s [4];
    val_t   r [4];
    val_t   rf, rb, best;
    ang_t   amax;
    wheel_t kb, pa, pb;

    function automatic val_t pick(input val_t a, input val_t b, input logic mn);
        if (mn) return (b < a) ? b : a;
        return (a < b) ? b : a;
    endfunction

    function automatic logic [32:0] mag(input val_t v);
        logic signed [32:0] e;
        e = {v[VAL_W-1], v};
        return (e < 0) ? -e : e;
    endfunction

    always_comb
    begin
        if (is_min)
        begin
            rf = (raw[0] < raw[1]) ? rr[0] : rr[1];
            rb = (raw[2] < raw[3]) ? rr[2] : rr[3];
        end
        else
        begin
            rf = (raw[0] > raw[1]) ? rr[0] : rr[1];
            rb = (raw[2] > raw[3]) ? rr[2] : rr[3];
        end
        for (int i = 0; i < 4; i++)
        begin
            s[i] = raw[i];
            r[i] = rr[i];
        end
        if (ctrl.virt && ctrl.weight)
        begin
            s[0] = wt[0];
            s[1] = wt[0];
            s[2] = vs[2];
            s[3] = vs[2];
            r[0] = rf;
            r[1] = rf;
            r[2] = rb;
            r[3] = rb;
        end
        else if (ctrl.virt)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s[i] = vs[i];
            end
            r[2] = rb;
            r[3] = rb;
        end
        else if (ctrl.weight)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s[i] = wt[i];
            end
            r[0] = rf;
            r[1] = rf;
            r[2] = rb;
            r[3] = rb;
        end
    end

    always_comb
    begin
        best = pick(pick(pick(s[0], s[1], is_min), s[2], is_min), s[3], is_min);
        amax = ang[0];
        for (int k = 1; k < 4; k++)
        begin
            if (ang[k] > amax) amax = ang[k];
        end
        if (s[0] == best) kb = 2'd0;
        else if (s[1] == best) kb = 2'd1;
        else if (s[2] == best) kb = 2'd2;
        else kb = 2'd3;
        pa = {idx[1], 1'b0};
        pb = {idx[1], 1'b1};

        slip  = pick(s[pa], s[pb], is_min);
        angle = (ang[pa] > ang[pb]) ? ang[pa] : ang[pb];
        rate  = (mag(s[pa]) > mag(s[pb])) ? r[pa] : r[pb];
        case (ctrl.mode)
            GRP_INDIVIDUAL:
            begin
                slip  = s[idx];
                angle = ang[idx];
                rate  = r[idx];
            end
            GRP_ALL:
            begin
                slip  = best;
                angle = amax;
                rate  = r[kb];
            end
            GRP_REAR:
            begin
                if (!idx[1])
                begin
                    slip  = '0;
                    angle = '0;
                    rate  = '0;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== design/wheel_slip_grouping_unit.sv =====
`timescale 1ns / 1ps
// Top level of the wheel slip grouping unit: configuration, sequencer and datapath.
// Depends on wsg_pkg, wsg_stream_if, wsg_frame_mem, wsg_state_mem, wsg_div and wsg_group.
//
//  Channel     Direction  Payload        Accepted when
//  wheel_item  in         wheel_item_t   valid && ready
//  result      out        result_t       valid && ready
//  cfg         in         cfg_write_t    valid && ready (ready is always high)
//
// Every wheel item is stored in the frame memory; items 0 to 2 do nothing more.
// The rear-right item starts a pass: READ, MUL and ACC for each wheel through the state
// memory, WPROD, WPREP and WWAIT for each axle with the two-bit-per-cycle divider (the
// divider is skipped when the axle load sum is not positive), and four result items,
// each of which waits while the previous result is stalled. The input is held off from
// the rear-right item until the last result is loaded; a stalled result does not block
// the next frame's first items.
// Reset sets the configuration to its defaults and clears the sequencer and the state memory valid bits.
module wheel_slip_grouping_unit (
    input logic          clk,
    input logic          rst_n,
    wsg_stream_if.sink   wheel_item,
    wsg_stream_if.source result,
    wsg_stream_if.sink   cfg
);
    import wsg_pkg::*;

    seq_state_t state_reg, state_next;

    logic              abs_virt_reg, abs_weight_reg, tc_virt_reg, tc_weight_reg;
    grp_mode_t         abs_mode_reg, tc_mode_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [POLE_W-1:0] pole_reg;

    wheel_t wheel_cnt_reg, emit_cnt_reg;
    logic   axle_reg;
    logic   out_valid_reg;
    result_t out_reg;

    val_t raw_reg [4];
    val_t vs_reg [4];
    val_t load_reg [4];
    val_t wt_reg [4];
    val_t rr_reg [4];
    ang_t ang_reg [4];

    logic signed [53:0] rate_prod_reg, rate_prod_next;
    logic signed [49:0] py_reg, py_next, px_reg, px_next;
    logic signed [63:0] p0_reg, p1_reg;
    logic signed [32:0] den_reg;
    logic               neg_reg;

    logic               in_acc, emit_load, div_start, div_done, div_ovf, axle_end;
    ang_t               div_q;
    frame_entry_t       frame_rd;
    wheel_state_t       st_rd;
    val_t               filt_new;
    logic [RATE_W-1:0]  rate_eff;
    logic [POLE_W-1:0]  pole_eff, pole_rest;
    logic signed [32:0] slip_diff;
    logic signed [50:0] filt_sum;
    logic signed [34:0] filt_floor;
    logic [63:0]        m0, m1, mag_sum;
    logic               n0, n1, neg_now;
    val_t               w_val;
    wheel_t             pa, pb;
    ctrl_src_t          abs_ctrl, tc_ctrl;
    val_t               abs_slip, abs_rate, tc_slip, tc_rate;
    ang_t               abs_angle, tc_angle;

    assign in_acc    = wheel_item.valid && wheel_item.ready;
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);
    assign div_start = (state_reg == ST_WPREP) && (den_reg > 33'sd0);
    assign axle_end  = ((state_reg == ST_WPREP) && !(den_reg > 33'sd0)) ||
                       ((state_reg == ST_WWAIT) && div_done);
    assign pa        = {axle_reg, 1'b0};
    assign pb        = {axle_reg, 1'b1};

    assign wheel_item.ready = (state_reg == ST_IDLE);
    assign cfg.ready        = 1'b1;
    assign result.valid     = out_valid_reg;
    assign result.data      = out_reg;

    wsg_frame_mem u_frame_mem (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (wheel_item.data.wheel),
        .wr_data ({wheel_item.data.wheel_slip, wheel_item.data.virtual_wheel_slip,
                   wheel_item.data.wheel_load, wheel_item.data.wheel_slip_angle}),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (wheel_cnt_reg),
        .rd_data (frame_rd)
    );

    wsg_state_mem u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (state_reg == ST_ACC),
        .wr_addr (wheel_cnt_reg),
        .wr_data ({frame_rd.slip, filt_new}),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (wheel_cnt_reg),
        .rd_data (st_rd)
    );

    wsg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_sum),
        .divisor  (den_reg[31:0]),
        .done     (div_done),
        .quotient (div_q),
        .overflow (div_ovf)
    );

    assign abs_ctrl = '{virt: abs_virt_reg, weight: abs_weight_reg, mode: abs_mode_reg};
    assign tc_ctrl  = '{virt: tc_virt_reg, weight: tc_weight_reg, mode: tc_mode_reg};

    wsg_group u_abs_group (
        .is_min (1'b1),
        .ctrl   (abs_ctrl),
        .idx    (emit_cnt_reg),
        .raw    (raw_reg),
        .vs     (vs_reg),
        .wt     (wt_reg),
        .rr     (rr_reg),
        .ang    (ang_reg),
        .slip   (abs_slip),
        .angle  (abs_angle),
        .rate   (abs_rate)
    );

    wsg_group u_tc_group (
        .is_min (1'b0),
        .ctrl   (tc_ctrl),
        .idx    (emit_cnt_reg),
        .raw    (raw_reg),
        .vs     (vs_reg),
        .wt     (wt_reg),
        .rr     (rr_reg),
        .ang    (ang_reg),
        .slip   (tc_slip),
        .angle  (tc_angle),
        .rate   (tc_rate)
    );

    // Per-wheel arithmetic: slip rate and angle filter products, then rounding and saturation.
    always_comb
    begin
        rate_eff       = (rate_reg > RATE_CAP) ? RATE_CAP : rate_reg;
        pole_eff       = (pole_reg > POLE_ONE) ? POLE_ONE : pole_reg;
        pole_rest      = POLE_ONE - pole_eff;
        slip_diff      = {frame_rd.slip[VAL_W-1], frame_rd.slip} -
                         {st_rd.prev[VAL_W-1], st_rd.prev};
        rate_prod_next = slip_diff * $signed({1'b0, rate_eff});
        py_next        = $signed({1'b0, pole_eff}) * st_rd.filt;
        px_next        = $signed({1'b0, pole_rest}) * frame_rd.angle;
        filt_sum       = {py_reg[49], py_reg} + {px_reg[49], px_reg} + 51'sd32768;
        filt_floor     = filt_sum[50:16];
        filt_new       = sat_val({{29{filt_floor[34]}}, filt_floor});
    end

    // Signed sum of the two load products, formed as sign and magnitude for the divider.
    always_comb
    begin
        n0 = p0_reg[63];
        n1 = p1_reg[63];
        m0 = n0 ? 64'(-p0_reg) : 64'(p0_reg);
        m1 = n1 ? 64'(-p1_reg) : 64'(p1_reg);
        if (n0 == n1)
        begin
            neg_now = n0;
            mag_sum = m0 + m1;
        end
        else if (m0 >= m1)
        begin
            neg_now = n0;
            mag_sum = m0 - m1;
        end
        else
        begin
            neg_now = n1;
            mag_sum = m1 - m0;
        end
        if (neg_reg) w_val = div_ovf ? VAL_MIN : -$signed({1'b0, div_q});
        else w_val = div_ovf ? VAL_MAX : $signed({1'b0, div_q});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && wheel_item.data.wheel == WHEEL_RR) state_next = ST_READ;
            end
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = (wheel_cnt_reg == WHEEL_RR) ? ST_WPROD : ST_READ;
            ST_WPROD: state_next = ST_WPREP;
            ST_WPREP:
            begin
                if (div_start) state_next = ST_WWAIT;
                else state_next = axle_reg ? ST_EMIT : ST_WPROD;
            end
            ST_WWAIT:
            begin
                if (div_done) state_next = axle_reg ? ST_EMIT : ST_WPROD;
            end
            ST_EMIT:
            begin
                if (emit_load && emit_cnt_reg == WHEEL_RR) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wheel_cnt_reg  <= '0;
            emit_cnt_reg   <= '0;
            axle_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            abs_virt_reg   <= 1'b0;
            abs_weight_reg <= 1'b0;
            tc_virt_reg    <= 1'b0;
            tc_weight_reg  <= 1'b0;
            abs_mode_reg   <= GRP_AXLE;
            tc_mode_reg    <= GRP_REAR;
            rate_reg       <= 20'd100;
            pole_reg       <= 17'd45875;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc && wheel_item.data.wheel == WHEEL_RR)
            begin
                wheel_cnt_reg <= '0;
                emit_cnt_reg  <= '0;
                axle_reg      <= 1'b0;
            end
            if (state_reg == ST_ACC)
            begin
                wheel_cnt_reg <= wheel_cnt_reg + 2'd1;
            end
            if (axle_end)
            begin
                axle_reg <= 1'b1;
            end
            if (emit_load)
            begin
                emit_cnt_reg  <= emit_cnt_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (reg_idx_t'(cfg.data.index))
                    REG_ABS_VIRTUAL: abs_virt_reg   <= cfg.data.value[0];
                    REG_ABS_WEIGHT:  abs_weight_reg <= cfg.data.value[0];
                    REG_TC_VIRTUAL:  tc_virt_reg    <= cfg.data.value[0];
                    REG_TC_WEIGHT:   tc_weight_reg  <= cfg.data.value[0];
                    REG_ABS_GROUP:   abs_mode_reg   <= grp_mode_t'(cfg.data.value[1:0]);
                    REG_TC_GROUP:    tc_mode_reg    <= grp_mode_t'(cfg.data.value[1:0]);
                    REG_SAMPLE_RATE: rate_reg       <= cfg.data.value;
                    REG_ANGLE_POLE:  pole_reg       <= cfg.data.value[POLE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            rate_prod_reg           <= rate_prod_next;
            py_reg                  <= py_next;
            px_reg                  <= px_next;
            raw_reg[wheel_cnt_reg]  <= frame_rd.slip;
            vs_reg[wheel_cnt_reg]   <= frame_rd.vslip;
            load_reg[wheel_cnt_reg] <= frame_rd.load;
        end
        if (state_reg == ST_ACC)
        begin
            rr_reg[wheel_cnt_reg]  <= sat_val({{10{rate_prod_reg[53]}}, rate_prod_reg});
            ang_reg[wheel_cnt_reg] <= abs_ang(filt_new);
        end
        if (state_reg == ST_WPROD)
        begin
            p0_reg  <= raw_reg[pa] * load_reg[pa];
            p1_reg  <= raw_reg[pb] * load_reg[pb];
            den_reg <= {load_reg[pa][VAL_W-1], load_reg[pa]} +
                       {load_reg[pb][VAL_W-1], load_reg[pb]};
        end
        if (state_reg == ST_WPREP)
        begin
            neg_reg <= neg_now;
            if (!div_start)
            begin
                wt_reg[pa] <= raw_reg[pa];
                wt_reg[pb] <= raw_reg[pb];
            end
        end
        if (state_reg == ST_WWAIT && div_done)
        begin
            wt_reg[pa] <= w_val;
            wt_reg[pb] <= w_val;
        end
        if (emit_load)
        begin
            out_reg.out_wheel   <= emit_cnt_reg;
            out_reg.abs_slip    <= abs_slip;
            out_reg.abs_angle   <= abs_angle;
            out_reg.abs_rate    <= abs_rate;
            out_reg.tc_slip     <= tc_slip;
            out_reg.tc_angle    <= tc_angle;
            out_reg.tc_rate     <= tc_rate;
            out_reg.final_wheel <= (emit_cnt_reg == WHEEL_RR);
        end
    end
endmodule

// ===== design/wsg_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the grouping unit's frame sequencing, bound to the top level.
// Depends on wsg_pkg and wheel_slip_grouping_unit.
module wsg_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input wsg_pkg::wheel_t in_wheel,
    input logic            out_valid,
    input logic            out_ready,
    input wsg_pkg::wheel_t out_wheel,
    input logic            out_final
);
    import wsg_pkg::*;

    a_busy_after_rr: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_wheel == WHEEL_RR |=> !in_ready)
        else $error("input accepted straight after a rear-right item");

    a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_final == (out_wheel == WHEEL_RR)))
        else $error("final flag does not match the rear-right result");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_wheel != WHEEL_RR |-> !in_ready)
        else $error("input open while a frame is still being emitted");

    a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_wheel != WHEEL_RR
        |=> out_valid && (out_wheel == $past(out_wheel) + 2'd1))
        else $error("results of a frame are not consecutive");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_wheel))
        else $error("stalled result changed");
endmodule

bind wheel_slip_grouping_unit wsg_checker u_wsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wheel_item.valid),
    .in_ready  (wheel_item.ready),
    .in_wheel  (wheel_item.data.wheel),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_wheel (result.data.out_wheel),
    .out_final (result.data.final_wheel)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the wheel slip grouping unit: frames of wheel items with random
// idling, a long result stall and several register settings, checked against a predictor.
// Depends on wsg_pkg, wsg_stream_if and wheel_slip_grouping_unit.
module tb;
    import wsg_pkg::*;

    typedef longint quad_t[4];

    class grouped_slip_board;
        logic [19:0] regs[8];
        longint      last_slip[4];
        longint      angle_state[4];
        longint      frame[4][4];
        result_t     pending_results[$];
        int          mismatches;

        function new();
            regs[REG_ABS_VIRTUAL] = 0;
            regs[REG_ABS_WEIGHT]  = 0;
            regs[REG_TC_VIRTUAL]  = 0;
            regs[REG_TC_WEIGHT]   = 0;
            regs[REG_ABS_GROUP]   = GRP_AXLE;
            regs[REG_TC_GROUP]    = GRP_REAR;
            regs[REG_SAMPLE_RATE] = 100;
            regs[REG_ANGLE_POLE]  = 45875;
            mismatches = 0;
            for (int i = 0; i < 4; i++)
            begin
                last_slip[i] = 0;
                angle_state[i] = 0;
                for (int j = 0; j < 4; j++)
                    frame[i][j] = 0;
            end
        endfunction

        function void note_register(reg_idx_t idx, logic [19:0] value);
            case (idx)
                REG_ABS_GROUP, REG_TC_GROUP: regs[idx] = value & 20'h3;
                REG_SAMPLE_RATE:             regs[idx] = value;
                REG_ANGLE_POLE:              regs[idx] = value & 20'h1FFFF;
                default:                     regs[idx] = value & 20'h1;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > VMAX64) return VMAX64;
            if (v < VMIN64) return VMIN64;
            return v;
        endfunction

        function bit axle_average(longint s0, longint l0, longint s1, longint l1,
                                  output longint res);
            longint      den;
            longint      p0;
            longint      p1;
            logic [63:0] m0;
            logic [63:0] m1;
            logic [63:0] m;
            logic [63:0] q;
            bit          neg;
            den = l0 + l1;
            p0 = s0 * l0;
            p1 = s1 * l1;
            res = 0;
            if (den <= 0)
                return 0;
            m0 = p0 < 0 ? -p0 : p0;
            m1 = p1 < 0 ? -p1 : p1;
            if ((p0 < 0) == (p1 < 0))
            begin
                neg = p0 < 0;
                m = m0 + m1;
            end
            else if (m0 >= m1)
            begin
                neg = p0 < 0;
                m = m0 - m1;
            end
            else
            begin
                neg = p1 < 0;
                m = m1 - m0;
            end
            q = m / den;
            if (q > 64'd2147483647)
                res = neg ? VMIN64 : VMAX64;
            else
                res = neg ? -longint'(q) : longint'(q);
            return 1;
        endfunction

        function longint pick(longint a, longint b, bit ismin);
            if (ismin)
                return b < a ? b : a;
            return a < b ? b : a;
        endfunction

        function longint sel(longint a, longint b, longint ra, longint rb, bit ismin);
            if (ismin)
                return a < b ? ra : rb;
            return a > b ? ra : rb;
        endfunction

        function void choose_source(bit virt, bit weight, bit ismin, quad_t raw, quad_t vs,
                                    quad_t wt, quad_t rr, output quad_t s, output quad_t r);
            longint rf;
            longint rb;
            rf = sel(raw[0], raw[1], rr[0], rr[1], ismin);
            rb = sel(raw[2], raw[3], rr[2], rr[3], ismin);
            s = raw;
            r = rr;
            if (virt && weight)
            begin
                s[0] = wt[0];
                s[1] = wt[0];
                s[2] = vs[2];
                s[3] = vs[2];
                r[0] = rf;
                r[1] = rf;
                r[2] = rb;
                r[3] = rb;
            end
            else if (virt)
            begin
                s = vs;
                r[2] = rb;
                r[3] = rb;
            end
            else if (weight)
            begin
                s = wt;
                r[0] = rf;
                r[1] = rf;
                r[2] = rb;
                r[3] = rb;
            end
        endfunction

        function void group_wheels(grp_mode_t mode, bit ismin, quad_t s, quad_t ang, quad_t r,
                                   output quad_t os, output quad_t oa, output quad_t orr);
            longint best;
            int     a;
            int     k;
            for (int i = 0; i < 4; i++)
            begin
                if (mode == GRP_INDIVIDUAL)
                begin
                    os[i] = s[i];
                    oa[i] = ang[i];
                    orr[i] = r[i];
                end
                else if (mode == GRP_ALL)
                begin
                    best = pick(pick(pick(s[0], s[1], ismin), s[2], ismin), s[3], ismin);
                    os[i] = best;
                    oa[i] = ang[0];
                    for (k = 1; k < 4; k++)
                        if (ang[k] > oa[i])
                            oa[i] = ang[k];
                    k = 0;
                    while (k < 3 && s[k] != best)
                        k++;
                    orr[i] = r[k];
                end
                else if (mode == GRP_REAR && i < 2)
                begin
                    os[i] = 0;
                    oa[i] = 0;
                    orr[i] = 0;
                end
                else
                begin
                    a = i < 2 ? 0 : 2;
                    os[i] = pick(s[a], s[a+1], ismin);
                    oa[i] = ang[a] > ang[a+1] ? ang[a] : ang[a+1];
                    orr[i] = (s[a] < 0 ? -s[a] : s[a]) > (s[a+1] < 0 ? -s[a+1] : s[a+1]) ?
                             r[a] : r[a+1];
                end
            end
        endfunction

        function void note_wheel(wheel_item_t it);
            quad_t   raw;
            quad_t   vs;
            quad_t   wt;
            quad_t   rr;
            quad_t   ang;
            quad_t   s;
            quad_t   r;
            quad_t   as_;
            quad_t   aa;
            quad_t   ar;
            quad_t   ts;
            quad_t   ta;
            quad_t   tr;
            longint  w;
            longint  rate;
            longint  pole;
            result_t res;
            frame[it.wheel][0] = it.wheel_slip;
            frame[it.wheel][1] = it.virtual_wheel_slip;
            frame[it.wheel][2] = it.wheel_load;
            frame[it.wheel][3] = it.wheel_slip_angle;
            if (it.wheel != WHEEL_RR)
                return;
            rate = regs[REG_SAMPLE_RATE] > 1000000 ? 1000000 : regs[REG_SAMPLE_RATE];
            pole = regs[REG_ANGLE_POLE] > 65536 ? 65536 : regs[REG_ANGLE_POLE];
            for (int i = 0; i < 4; i++)
            begin
                raw[i] = frame[i][0];
                vs[i] = frame[i][1];
                wt[i] = raw[i];
                rr[i] = clamp((raw[i] - last_slip[i]) * rate);
                last_slip[i] = raw[i];
                angle_state[i] = clamp((pole * angle_state[i] + (65536 - pole) * frame[i][3]
                                        + 32768) >>> 16);
                ang[i] = angle_state[i] < 0 ? -angle_state[i] : angle_state[i];
                if (ang[i] > VMAX64)
                    ang[i] = VMAX64;
            end
            if (axle_average(raw[0], frame[0][2], raw[1], frame[1][2], w))
            begin
                wt[0] = w;
                wt[1] = w;
            end
            if (axle_average(raw[2], frame[2][2], raw[3], frame[3][2], w))
            begin
                wt[2] = w;
                wt[3] = w;
            end
            choose_source(regs[REG_ABS_VIRTUAL][0], regs[REG_ABS_WEIGHT][0], 1,
                          raw, vs, wt, rr, s, r);
            group_wheels(grp_mode_t'(regs[REG_ABS_GROUP][1:0]), 1, s, ang, r, as_, aa, ar);
            choose_source(regs[REG_TC_VIRTUAL][0], regs[REG_TC_WEIGHT][0], 0,
                          raw, vs, wt, rr, s, r);
            group_wheels(grp_mode_t'(regs[REG_TC_GROUP][1:0]), 0, s, ang, r, ts, ta, tr);
            for (int i = 0; i < 4; i++)
            begin
                res.out_wheel   = wheel_t'(i);
                res.abs_slip    = as_[i][31:0];
                res.abs_angle   = aa[i][30:0];
                res.abs_rate    = ar[i][31:0];
                res.tc_slip     = ts[i][31:0];
                res.tc_angle    = ta[i][30:0];
                res.tc_rate     = tr[i][31:0];
                res.final_wheel = (i == 3);
                pending_results.push_back(res);
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                $error("result item with no expectation: %p", got);
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.out_wheel !== exp.out_wheel)
            begin
                $error("out_wheel: expected %0d, got %0d", exp.out_wheel, got.out_wheel);
                mismatches++;
            end
            if (got.abs_slip !== exp.abs_slip)
            begin
                $error("abs_slip: expected %0d, got %0d", exp.abs_slip, got.abs_slip);
                mismatches++;
            end
            if (got.abs_angle !== exp.abs_angle)
            begin
                $error("abs_angle: expected %0d, got %0d", exp.abs_angle, got.abs_angle);
                mismatches++;
            end
            if (got.abs_rate !== exp.abs_rate)
            begin
                $error("abs_rate: expected %0d, got %0d", exp.abs_rate, got.abs_rate);
                mismatches++;
            end
            if (got.tc_slip !== exp.tc_slip)
            begin
                $error("tc_slip: expected %0d, got %0d", exp.tc_slip, got.tc_slip);
                mismatches++;
            end
            if (got.tc_angle !== exp.tc_angle)
            begin
                $error("tc_angle: expected %0d, got %0d", exp.tc_angle, got.tc_angle);
                mismatches++;
            end
            if (got.tc_rate !== exp.tc_rate)
            begin
                $error("tc_rate: expected %0d, got %0d", exp.tc_rate, got.tc_rate);
                mismatches++;
            end
            if (got.final_wheel !== exp.final_wheel)
            begin
                $error("final_wheel: expected %0d, got %0d", exp.final_wheel,
                       got.final_wheel);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    int   cycles = 0;
    bit   idling = 1;
    int   hold_request = 0;
    int   sent = 0;

    grouped_slip_board board = new();

    wsg_stream_if #(.payload_t(wheel_item_t)) wheel_if ();
    wsg_stream_if #(.payload_t(result_t))     result_if ();
    wsg_stream_if #(.payload_t(cfg_write_t))  cfg_if ();

    wheel_slip_grouping_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .wheel_item (wheel_if),
        .result     (result_if),
        .cfg        (cfg_if)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    initial
    begin
        wheel_if.valid = 0;
        wheel_if.data = '0;
        cfg_if.valid = 0;
        cfg_if.data = '0;
        result_if.ready = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == 600000)
        begin
            $display("wheel_slip_grouping_unit regression: fail");
            $finish;
        end
    end

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
                board.check_result(result_if.data);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 0;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                result_if.ready <= 0;
            end
            else
                result_if.ready <= 1;
        end
    end

    function automatic val_t any_value();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return VAL_MAX;
            2: return VAL_MIN;
            3: return val_t'($urandom_range(0, 262144)) - 131072;
            4: return val_t'($urandom_range(0, 8000000)) - 4000000;
            default: return val_t'($urandom);
        endcase
    endfunction

    function automatic val_t any_load();
        case ($urandom_range(0, 9))
            0: return any_value();
            1: return -val_t'($urandom_range(0, 2000000));
            2: return 0;
            default: return val_t'($urandom_range(1, 40000000));
        endcase
    endfunction

    task automatic send_wheel(wheel_t w, val_t slip, val_t vslip, val_t load, val_t angle);
        wheel_item_t it;
        it.wheel = w;
        it.wheel_slip = slip;
        it.virtual_wheel_slip = vslip;
        it.wheel_load = load;
        it.wheel_slip_angle = angle;
        wheel_if.data <= it;
        wheel_if.valid <= 1;
        @(posedge clk);
        while (!wheel_if.ready)
            @(posedge clk);
        board.note_wheel(it);
        sent++;
        if (idling && $urandom_range(0, 4) == 0)
        begin
            wheel_if.valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_random(wheel_t w);
        send_wheel(w, any_value(), any_value(), any_load(), any_value());
    endtask

    task automatic write_reg(reg_idx_t idx, logic [19:0] value);
        cfg_if.data <= '{index: idx, value: value};
        cfg_if.valid <= 1;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        board.note_register(idx, value);
    endtask

    task automatic set_registers(logic [19:0] v[8]);
        for (int i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), v[i]);
        cfg_if.valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        wheel_if.valid <= 0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic send_frames(int count);
        int order[3];
        int t;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                order = '{0, 1, 2};
                for (int i = 2; i > 0; i--)
                begin
                    t = $urandom_range(0, i);
                    {order[i], order[t]} = {order[t], order[i]};
                end
                for (int i = 0; i < 3; i++)
                    send_random(wheel_t'(order[i]));
                if ($urandom_range(0, 5) == 0)
                    send_random(wheel_t'($urandom_range(0, 2)));
                send_random(WHEEL_RR);
            end
            else
                send_random(wheel_t'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin : stimulus
        logic [19:0] v[8];
        repeat (8) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        send_wheel(0, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN);
        send_wheel(1, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX);
        send_wheel(2, 0, 0, 0, 0);
        send_wheel(3, 32'sd65536, -32'sd65536, 0, VAL_MIN);
        send_wheel(0, 32'sd1000, 32'sd5, -32'sd65536, 32'sd65536);
        send_wheel(1, 32'sd1000, 32'sd5, -32'sd65536, -32'sd65536);
        send_wheel(2, -32'sd200, 32'sd7, 32'sd65536, 32'sd1);
        send_wheel(3, -32'sd200, 32'sd7, -32'sd65536, -32'sd1);
        drain();

        v = '{1, 1, 1, 1, GRP_ALL, GRP_ALL, 0, 0};
        set_registers(v);
        send_wheel(0, 32'sd300, 32'sd9, 32'sd65536, VAL_MAX);
        send_wheel(1, -32'sd300, 32'sd9, 32'sd131072, VAL_MIN);
        send_wheel(2, 32'sd300, -32'sd9, 32'sd1, 32'sd77);
        send_wheel(3, -32'sd300, -32'sd9, 32'sd1, -32'sd77);
        drain();

        v = '{1, 0, 1, 0, GRP_INDIVIDUAL, GRP_AXLE, 20'hFFFFF, 20'h1FFFF};
        set_registers(v);
        send_wheel(0, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX);
        send_wheel(2, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        send_wheel(1, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN);
        send_wheel(3, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN);
        drain();

        v = '{0, 1, 0, 1, GRP_REAR, GRP_INDIVIDUAL, 1000000, 65536};
        set_registers(v);
        send_frames(8);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            idling = phase != 5 && phase != 7;
            for (int i = 0; i < 4; i++)
                v[i] = $urandom_range(0, 1);
            v[REG_ABS_GROUP] = $urandom_range(0, 3);
            v[REG_TC_GROUP] = $urandom_range(0, 3);
            v[REG_SAMPLE_RATE] = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20'hFFFFF)
                                                           : $urandom_range(1, 2000);
            v[REG_ANGLE_POLE] = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20'h1FFFF)
                                                          : $urandom_range(30000, 65536);
            set_registers(v);
            if (phase == 2)
                hold_request = 500;
            send_frames(phase == 7 ? 10 : 9);
            drain();
        end

        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("wheel_slip_grouping_unit regression: pass");
        else
            $display("wheel_slip_grouping_unit regression: fail");
        $finish;
    end
endmodule
